@@ rtl/core/fwrs_pkg.sv @@
// ----------------------------------------------------------------------------
// fwrs_pkg
// Types, constants and register map for the fixed-weight rejection sampler.
// ----------------------------------------------------------------------------
package fwrs_pkg;

  localparam int MAX_WEIGHT_DEF = 128;
  localparam int INDEX_BITS_DEF = 16;

  localparam int WORD_W   = 24;
  localparam int POS_W    = 16;
  localparam int SLOT_W   = 7;
  localparam int MOD_W    = 16;
  localparam int MU_W     = 32;
  localparam int THR_W    = 25;
  localparam int WEIGHT_W = 8;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 4;
  localparam int MUL_W    = 32;

  localparam logic [MOD_W-1:0]    MODULUS_RST = 16'd17669;
  localparam logic [MU_W-1:0]     MU_RST      = 32'd243079;
  localparam logic [THR_W-1:0]    THR_RST     = 25'd16767881;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST  = 8'd75;

  typedef enum logic [1:0] {
    REG_MODULUS = 2'd0,
    REG_MU      = 2'd1,
    REG_THR     = 2'd2,
    REG_WEIGHT  = 2'd3
  } reg_idx_t;

  typedef enum logic {
    ACT_WORD  = 1'b0,
    ACT_START = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_Q,
    ST_MUL_R,
    ST_REDUCE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic              action;
    logic [WORD_W-1:0] random_word;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } result_t;

endpackage

@@ rtl/core/fixed_weight_rejection_sampler.sv @@
// ----------------------------------------------------------------------------
// fixed_weight_rejection_sampler
// Rejection-samples random words into a set of distinct positions.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Beat
// item      in         start & !busy             action, random_word
// result    out        result_valid (1 cycle)    position, slot, last
// config    in         APB, pready tied high     modulus, mu, threshold, weight
//
// Start commands and rejected or post-full words finish at the accepting edge.
// A kept word holds busy for two passes through the shared multiplier, one
// reduce step, then a scan that reads each stored position through the single
// read port of the position memory and compares it with the candidate, and
// a finish step. A duplicate ends the scan early. The result beat appears in
// the same cycle in which busy falls.
// Reset empties the set and loads the register defaults; no clearing pass.
// The result strobe cannot be stalled.
module fixed_weight_rejection_sampler #(
  parameter int MAX_WEIGHT = fwrs_pkg::MAX_WEIGHT_DEF,
  parameter int INDEX_BITS = fwrs_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  fwrs_pkg::item_t               item,
  output logic                          result_valid,
  output fwrs_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fwrs_pkg::ADDR_W-1:0]   paddr,
  input  logic [fwrs_pkg::DATA_W-1:0]   pwdata,
  output logic [fwrs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int CW  = $clog2(MAX_WEIGHT + 1);
  localparam int AW  = (MAX_WEIGHT > 1) ? $clog2(MAX_WEIGHT) : 1;
  localparam int LW  = (CW > fwrs_pkg::WEIGHT_W) ? CW : fwrs_pkg::WEIGHT_W;
  localparam int MW  = fwrs_pkg::MUL_W;
  localparam logic [LW-1:0] MAX_W_L = LW'(MAX_WEIGHT);

  // configuration
  logic [fwrs_pkg::MOD_W-1:0]    modulus;
  logic [fwrs_pkg::MU_W-1:0]     barrett_mu;
  logic [fwrs_pkg::THR_W-1:0]    reject_threshold;
  logic [fwrs_pkg::WEIGHT_W-1:0] weight;
  logic                          cfg_wr;
  fwrs_pkg::reg_idx_t            cfg_idx;

  // datapath
  fwrs_pkg::state_t        state, state_next;
  logic [fwrs_pkg::WORD_W-1:0] word;
  logic [2*MW-1:0]         prod;
  logic [MW-1:0]           mul_a, mul_b;
  logic                    mul_en;
  logic [MW-1:0]           rem, rem_sub;
  logic [INDEX_BITS-1:0]   cand;
  logic [CW-1:0]           count;
  logic [CW-1:0]           rd_idx;
  logic                    pending;
  logic [INDEX_BITS-1:0]   mem_q;
  logic [INDEX_BITS-1:0]   mem [MAX_WEIGHT];
  logic [LW-1:0]           limit;
  logic [LW-1:0]           count_ext;
  logic                    full;
  logic                    accept;
  logic                    kept;
  logic                    issue;
  logic                    hit;
  logic                    finish;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = fwrs_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= fwrs_pkg::MODULUS_RST;
      barrett_mu       <= fwrs_pkg::MU_RST;
      reject_threshold <= fwrs_pkg::THR_RST;
      weight           <= fwrs_pkg::WEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        fwrs_pkg::REG_MODULUS: modulus          <= pwdata[fwrs_pkg::MOD_W-1:0];
        fwrs_pkg::REG_MU:      barrett_mu       <= pwdata[fwrs_pkg::MU_W-1:0];
        fwrs_pkg::REG_THR:     reject_threshold <= pwdata[fwrs_pkg::THR_W-1:0];
        fwrs_pkg::REG_WEIGHT:  weight           <= pwdata[fwrs_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      fwrs_pkg::REG_MODULUS: prdata = fwrs_pkg::DATA_W'(modulus);
      fwrs_pkg::REG_MU:      prdata = fwrs_pkg::DATA_W'(barrett_mu);
      fwrs_pkg::REG_THR:     prdata = fwrs_pkg::DATA_W'(reject_threshold);
      fwrs_pkg::REG_WEIGHT:  prdata = fwrs_pkg::DATA_W'(weight);
      default:               prdata = '0;
    endcase
  end

  // set limit and admission
  assign limit     = (LW'(weight) > MAX_W_L) ? MAX_W_L : LW'(weight);
  assign count_ext = LW'(count);
  assign full      = count_ext >= limit;
  assign busy      = state != fwrs_pkg::ST_IDLE;
  assign accept    = start & ~busy;
  assign kept      = accept & (item.action == fwrs_pkg::ACT_WORD) & ~full &
                     ({1'b0, item.random_word} < reject_threshold);

  // Barrett remainder and one conditional subtract
  assign rem     = MW'(word) - prod[MW-1:0];
  assign rem_sub = rem - MW'(modulus);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fwrs_pkg::ST_IDLE:   if (kept) state_next = fwrs_pkg::ST_MUL_Q;
      fwrs_pkg::ST_MUL_Q:  state_next = fwrs_pkg::ST_MUL_R;
      fwrs_pkg::ST_MUL_R:  state_next = fwrs_pkg::ST_REDUCE;
      fwrs_pkg::ST_REDUCE: state_next = fwrs_pkg::ST_SCAN;
      fwrs_pkg::ST_SCAN:   if (hit || finish) state_next = fwrs_pkg::ST_IDLE;
      default:             state_next = fwrs_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    issue  = 1'b0;
    hit    = 1'b0;
    finish = 1'b0;
    case (state)
      fwrs_pkg::ST_MUL_Q: begin
        mul_a  = barrett_mu;
        mul_b  = MW'(word);
        mul_en = 1'b1;
      end
      fwrs_pkg::ST_MUL_R: begin
        mul_a  = MW'(modulus);
        mul_b  = MW'(prod[MW +: fwrs_pkg::WORD_W]);
        mul_en = 1'b1;
      end
      fwrs_pkg::ST_SCAN: begin
        hit    = pending && (mem_q == cand);
        issue  = !hit && (rd_idx < count);
        finish = !hit && !pending && !(rd_idx < count);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fwrs_pkg::ST_IDLE;
      count        <= '0;
      pending      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= finish;
      pending      <= issue;
      if (accept && item.action == fwrs_pkg::ACT_START) begin
        count <= '0;
      end else if (finish) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (kept) begin
      word <= item.random_word;
    end
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (state == fwrs_pkg::ST_REDUCE) begin
      cand   <= rem_sub[MW-1] ? rem[INDEX_BITS-1:0] : rem_sub[INDEX_BITS-1:0];
      rd_idx <= '0;
    end else if (issue) begin
      rd_idx <= rd_idx + 1'b1;
    end
    if (finish) begin
      result.position <= fwrs_pkg::POS_W'(cand);
      result.slot     <= fwrs_pkg::SLOT_W'(count);
      result.last     <= (count_ext + 1'b1) == limit;
    end
  end

  // position memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (finish) begin
      mem[count[AW-1:0]] <= cand;
    end
    mem_q <= mem[rd_idx[AW-1:0]];
  end

endmodule
